[src/swtd_pkg.sv]
package swtd_pkg;

  // fraction digits kept in the split (1 to 2)
  localparam int unsigned FracDigits = 2;
  localparam int unsigned FracScale  = 10 ** FracDigits;
  // fraction value width before it is cut to the 7-bit field
  localparam int unsigned FracW      = 10;

  // request queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // reciprocal constants for division by a constant
  localparam logic [63:0] RecipSec  = 64'd274877907;  // x / 1000, shift 38
  localparam int unsigned ShSec     = 38;
  localparam logic [52:0] RecipMin  = 53'd8947849;    // x / 60 (23-bit x), shift 29
  localparam int unsigned ShMin     = 29;
  localparam logic [38:0] RecipHour = 39'd69906;      // x / 60 (17-bit x), shift 22
  localparam int unsigned ShHour    = 22;
  localparam logic [50:0] RecipFrac = 51'd1073742;    // x / 1000 (20-bit x), shift 30
  localparam int unsigned ShFrac    = 30;

  localparam logic [1:0] CfgFracReset = 2'd1;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_PRESET = 2'd3
  } req_e;

  // what the back part has to do with a transaction
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        paused;
    logic [31:0] ms;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // decimal digit count of the hours field (up to four digits)
  function automatic logic [2:0] digits_hours(input logic [10:0] v);
    logic [2:0] n;
    if (v >= 11'd1000) begin
      n = 3'd4;
    end else if (v >= 11'd100) begin
      n = 3'd3;
    end else if (v >= 11'd10) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  // decimal digit count of a minutes or seconds field
  function automatic logic [1:0] digits_small(input logic [5:0] v);
    logic [1:0] n;
    n = (v >= 6'd10) ? 2'd2 : 2'd1;
    return n;
  endfunction

endpackage

[src/swtd_front.sv]
module swtd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        preset_ms_i,
  input  swtd_pkg::q_status_t q_status_i,
  output logic               push_o,
  output swtd_pkg::job_t     job_o
);
  import swtd_pkg::*;

  logic        running_q, running_d;
  logic [31:0] start_tick_q, start_tick_d;
  logic [31:0] base_ms_q, base_ms_d;
  logic [31:0] current_ms_q, current_ms_d;
  logic        accept;
  req_e        req;

  assign s_ready_o = !q_status_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = accept;
  assign req       = req_e'(req_type_i);

  // stopwatch state update and classification of the transaction
  always_comb begin
    running_d    = running_q;
    start_tick_d = start_tick_q;
    base_ms_d    = base_ms_q;
    current_ms_d = current_ms_q;
    job_o.kind   = KIND_NONE;
    job_o.paused = 1'b0;
    job_o.ms     = current_ms_q;
    case (req)
      REQ_UPDATE: begin
        if (running_q) begin
          current_ms_d = base_ms_q + (now_ms_i - start_tick_q);
        end
        job_o.kind   = KIND_UPDATE;
        job_o.paused = !running_q;
        job_o.ms     = current_ms_d;
      end
      REQ_START: begin
        if (!running_q) begin
          running_d    = 1'b1;
          start_tick_d = now_ms_i;
        end
      end
      REQ_STOP: begin
        if (running_q) begin
          running_d  = 1'b0;
          base_ms_d  = current_ms_q;
          job_o.kind = KIND_STOP;
        end
      end
      REQ_PRESET: begin
        current_ms_d = preset_ms_i;
        base_ms_d    = preset_ms_i;
        start_tick_d = now_ms_i;
      end
      default: begin
        job_o.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      start_tick_q <= '0;
      base_ms_q    <= '0;
      current_ms_q <= '0;
    end else if (accept) begin
      running_q    <= running_d;
      start_tick_q <= start_tick_d;
      base_ms_q    <= base_ms_d;
      current_ms_q <= current_ms_d;
    end
  end

endmodule

[src/swtd_queue.sv]
module swtd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  swtd_pkg::job_t      push_job_i,
  input  logic                pop_i,
  output swtd_pkg::job_t      pop_job_o,
  output swtd_pkg::q_status_t status_o
);
  import swtd_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.valid = (count_q != '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign pop_job_o      = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[src/swtd_back.sv]
module swtd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  swtd_pkg::q_status_t q_status_i,
  input  swtd_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [39:0]         m_data_o,
  output logic [1:0]          m_user_o
);
  import swtd_pkg::*;

  logic [1:0] frac_shown_q;

  // pipeline stage registers
  logic        v1_q, v2_q, v3_q, v4_q;
  kind_e       k1_q, k2_q, k3_q, k4_q;
  logic        p1_q, p2_q, p3_q, p4_q;
  logic [31:0] ms1_q;
  logic [22:0] sec1_q, sec2_q;
  logic [9:0]  rem2_q;
  logic [16:0] min2_q, min3_q;
  logic [5:0]  s3_q, s4_q;
  logic [10:0] h3_q, h4_q;
  logic [19:0] pf3_q;
  logic [5:0]  m4_q;
  logic [FracW-1:0] f4_q;

  // last shown split
  logic [10:0]      sh_h_q;
  logic [5:0]       sh_m_q, sh_s_q;
  logic [FracW-1:0] sh_f_q;

  // output register
  logic        out_valid_q;
  logic [39:0] out_data_q;
  logic [1:0]  out_user_q;

  logic        adv;
  logic [63:0] prod_sec;
  logic [31:0] sec_x1000;
  logic [52:0] prod_min;
  logic [22:0] min_x60;
  logic [38:0] prod_hour;
  logic [16:0] hour_x60;
  logic [50:0] prod_frac;

  logic        refresh, upd, pau;
  logic [10:0] nh;
  logic [5:0]  nm, ns;
  logic [FracW-1:0] nf;
  logic [2:0]  hd;
  logic [1:0]  md, sd, mask;

  assign adv       = !out_valid_q || m_ready_i;
  assign pop_o     = adv && q_status_i.valid;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = out_user_q;

  // shown fraction digits register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_shown_q <= CfgFracReset;
    end else if (cfg_we_i) begin
      frac_shown_q <= cfg_wdata_i;
    end
  end

  // constant divisions by reciprocal multiplication
  assign prod_sec  = {32'b0, job_i.ms} * RecipSec;
  assign sec_x1000 = {9'b0, sec1_q} * 32'd1000;
  assign prod_min  = {30'b0, sec1_q} * RecipMin;
  assign min_x60   = {6'b0, min2_q} * 23'd60;
  assign prod_hour = {22'b0, min2_q} * RecipHour;
  assign hour_x60  = {6'b0, h3_q} * 17'd60;
  assign prod_frac = {31'b0, pf3_q} * RecipFrac;

  // valid bits move together under one advance enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_status_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // seconds
      k1_q   <= job_i.kind;
      p1_q   <= job_i.paused;
      ms1_q  <= job_i.ms;
      sec1_q <= prod_sec[ShSec +: 23];
      // millisecond remainder and whole minutes
      k2_q   <= k1_q;
      p2_q   <= p1_q;
      sec2_q <= sec1_q;
      rem2_q <= 10'(ms1_q - sec_x1000);
      min2_q <= prod_min[ShMin +: 17];
      // seconds within minute, hours, scaled fraction
      k3_q   <= k2_q;
      p3_q   <= p2_q;
      min3_q <= min2_q;
      s3_q   <= 6'(sec2_q - min_x60);
      h3_q   <= prod_hour[ShHour +: 11];
      pf3_q  <= {10'b0, rem2_q} * 20'(FracScale);
      // minutes within hour, fraction digits
      k4_q   <= k3_q;
      p4_q   <= p3_q;
      s4_q   <= s3_q;
      h4_q   <= h3_q;
      m4_q   <= 6'(min3_q - hour_x60);
      f4_q   <= prod_frac[ShFrac +: FracW];
    end
  end

  // refresh decision and display layout
  always_comb begin
    refresh = 1'b0;
    upd     = 1'b0;
    pau     = 1'b0;
    mask    = 2'b00;
    nh      = sh_h_q;
    nm      = sh_m_q;
    ns      = sh_s_q;
    nf      = sh_f_q;
    case (k4_q)
      KIND_UPDATE: begin
        if (h4_q != sh_h_q || m4_q != sh_m_q || s4_q != sh_s_q || f4_q != sh_f_q) begin
          refresh = 1'b1;
          upd     = 1'b1;
          pau     = p4_q;
          nh      = h4_q;
          nm      = m4_q;
          ns      = s4_q;
          nf      = f4_q;
          for (int i = 0; i < 2; i++) begin
            if (!p4_q && (i < int'(FracDigits)) && (i >= int'(frac_shown_q))) begin
              mask[i] = 1'b1;
            end
          end
        end
      end
      KIND_STOP: begin
        upd = 1'b1;
        pau = 1'b1;
      end
      default: begin
        upd = 1'b0;
      end
    endcase
    hd = (nh != '0) ? digits_hours(nh) : 3'd0;
    if (nh != '0) begin
      md = 2'd2;
      sd = 2'd2;
    end else if (nm != '0) begin
      md = digits_small(nm);
      sd = 2'd2;
    end else begin
      md = 2'd0;
      sd = digits_small(ns);
    end
  end

  // last shown split
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_h_q <= '0;
      sh_m_q <= '0;
      sh_s_q <= '0;
      sh_f_q <= '0;
    end else if (adv && v4_q && refresh) begin
      sh_h_q <= nh;
      sh_m_q <= nm;
      sh_s_q <= ns;
      sh_f_q <= nf;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v4_q) begin
      out_user_q <= {pau, upd};
      out_data_q <= {1'b0, mask, sd, md, hd, nf[6:0], ns, nm, nh};
    end
  end

endmodule

[src/stopwatch_time_display.sv]
// millisecond stopwatch with display layout
// input channel s_axis: one request per transaction; tuser carries the request
// kind (update, start, stop, preset), tdata the tick count and the preset time
// output channel m_axis: exactly one result transaction per request, in order;
// tuser flags a refreshed display and a paused one, tdata the time split into
// hours, minutes, seconds and hundredths with digit counts and blanking mask
// cfg_we_i/cfg_wdata_i write the number of fraction digits shown while running
// a request updates the stopwatch state in the cycle it is accepted; the
// split then runs through a five-stage reciprocal-multiply pipeline
// throughput is one request per cycle while the receiver takes results, set by that pipeline
// when the receiver stalls, the pipeline holds and a four-entry request queue
// fills; s_axis_tready_o falls only when the queue is full
// after reset the watch is stopped at zero, with one fraction digit shown
module stopwatch_time_display (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // now_ms [31:0], preset_ms [63:32]
  input  logic [1:0]  s_axis_tuser_i,   // req_type [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // hours [10:0], minutes [16:11], seconds [22:17], hundredths [29:23],
  // hour_digits [32:30], minute_digits [34:33], second_digits [36:35],
  // frac_blank_mask [38:37], zero [39]
  output logic [39:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // updated [0], paused [1]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);
  import swtd_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  job_t      push_job, pop_job;

  swtd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .now_ms_i    (s_axis_tdata_i[31:0]),
    .preset_ms_i (s_axis_tdata_i[63:32]),
    .q_status_i  (q_status),
    .push_o      (push),
    .job_o       (push_job)
  );

  swtd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .status_o   (q_status)
  );

  swtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_status_i  (q_status),
    .job_i       (pop_job),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_user_o    (m_axis_tuser_o)
  );

  // a paused display is always a refreshed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("paused result without refresh");

  // blanking only on an unpaused refresh
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[38:37] != 2'b00)
      |-> m_axis_tuser_o[0] && !m_axis_tuser_o[1])
    else $error("fraction blanked outside an unpaused refresh");

  // hour digit count zero exactly when hours are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[32:30] == 3'd0) == (m_axis_tdata_o[10:0] == 11'd0)))
    else $error("hour digit count disagrees with hours");

  // a full queue only arises while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("request queue full without an output stall");

endmodule

[verif/tb_stopwatch_time_display.sv]
`timescale 1ns / 1ps

module tb_stopwatch_time_display;
  import swtd_pkg::*;

  // one display result as it leaves the block
  typedef struct packed {
    logic        updated;
    logic        paused;
    logic [10:0] hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [6:0]  hundredths;
    logic [2:0]  hour_digits;
    logic [1:0]  minute_digits;
    logic [1:0]  second_digits;
    logic [1:0]  frac_blank_mask;
  } display_t;

  // stopwatch state mirror and the queue of displays still owed
  class display_scoreboard;
    bit          running;
    logic [31:0] start_tick;
    logic [31:0] base_ms;
    logic [31:0] current_ms;
    int unsigned shown_h, shown_m, shown_s, shown_f;
    logic [1:0]  frac_shown;
    display_t    expected_displays[$];
    int unsigned errors;

    function new();
      running    = 1'b0;
      start_tick = '0;
      base_ms    = '0;
      current_ms = '0;
      shown_h    = 0;
      shown_m    = 0;
      shown_s    = 0;
      shown_f    = 0;
      frac_shown = CfgFracReset;
      errors     = 0;
    endfunction

    function int unsigned count_digits(int unsigned v);
      int unsigned n;
      n = 1;
      while (v >= 10) begin
        v = v / 10;
        n++;
      end
      return n;
    endfunction

    // fraction digits at or past the shown count are blanked
    function logic [1:0] blank_mask();
      logic [1:0] m;
      m = '0;
      for (int i = 0; i < FracDigits && i < 2; i++) begin
        if (i >= frac_shown) m[i] = 1'b1;
      end
      return m;
    endfunction

    // layout of the last shown time
    function display_t shown_layout(bit refreshed, bit paused, logic [1:0] mask);
      display_t d;
      d                 = '0;
      d.updated         = refreshed;
      d.paused          = paused;
      d.hours           = shown_h[10:0];
      d.minutes         = shown_m[5:0];
      d.seconds         = shown_s[5:0];
      d.hundredths      = shown_f[6:0];
      d.hour_digits     = (shown_h != 0) ? 3'(count_digits(shown_h)) : 3'd0;
      d.frac_blank_mask = mask;
      if (shown_h != 0) begin
        d.minute_digits = 2'd2;
        d.second_digits = 2'd2;
      end else if (shown_m != 0) begin
        d.minute_digits = 2'(count_digits(shown_m));
        d.second_digits = 2'd2;
      end else begin
        d.minute_digits = 2'd0;
        d.second_digits = 2'(count_digits(shown_s));
      end
      return d;
    endfunction

    function void note_request(req_e req, logic [31:0] now_ms, logic [31:0] preset_ms);
      int unsigned secs, h, m, s, f;
      bit          refreshed, paused;
      logic [1:0]  mask;
      refreshed = 1'b0;
      paused    = 1'b0;
      mask      = '0;
      case (req)
        REQ_UPDATE: begin
          if (running) current_ms = base_ms + (now_ms - start_tick);
          secs = current_ms / 1000;
          h    = secs / 3600;
          m    = (secs / 60) % 60;
          s    = secs % 60;
          f    = (current_ms % 1000) * FracScale / 1000;
          if (h != shown_h || m != shown_m || s != shown_s || f != shown_f) begin
            shown_h   = h;
            shown_m   = m;
            shown_s   = s;
            shown_f   = f;
            refreshed = 1'b1;
            paused    = !running;
            mask      = paused ? 2'b00 : blank_mask();
          end
        end
        REQ_START: begin
          if (!running) begin
            running    = 1'b1;
            start_tick = now_ms;
          end
        end
        REQ_STOP: begin
          // freeze at the time of the last update
          if (running) begin
            running   = 1'b0;
            base_ms   = current_ms;
            refreshed = 1'b1;
            paused    = 1'b1;
          end
        end
        default: begin
          current_ms = preset_ms;
          base_ms    = preset_ms;
          start_tick = now_ms;
        end
      endcase
      expected_displays.insert(expected_displays.size(),
                               shown_layout(refreshed, paused, mask));
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_display(logic [39:0] tdata, logic [1:0] tuser);
      display_t want;
      if (expected_displays.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      want = expected_displays.pop_front();
      compare("updated", 32'(want.updated), 32'(tuser[0]));
      compare("paused", 32'(want.paused), 32'(tuser[1]));
      compare("hours", 32'(want.hours), 32'(tdata[10:0]));
      compare("minutes", 32'(want.minutes), 32'(tdata[16:11]));
      compare("seconds", 32'(want.seconds), 32'(tdata[22:17]));
      compare("hundredths", 32'(want.hundredths), 32'(tdata[29:23]));
      compare("hour_digits", 32'(want.hour_digits), 32'(tdata[32:30]));
      compare("minute_digits", 32'(want.minute_digits), 32'(tdata[34:33]));
      compare("second_digits", 32'(want.second_digits), 32'(tdata[36:35]));
      compare("frac_blank_mask", 32'(want.frac_blank_mask), 32'(tdata[38:37]));
      compare("zero pad", 32'd0, 32'(tdata[39]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_hold_pending = 1'b0;
  int unsigned rx_hold_left = 0;
  logic [31:0] tick;
  display_scoreboard display_sb;

  stopwatch_time_display dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_pending) begin
      rx_hold_left    = 300;
      rx_hold_pending = 1'b0;
    end
    if (rx_hold_left != 0) begin
      m_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_ready <= !(rx_idle_en && $urandom_range(99) < 31);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      display_sb.check_display(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // offer one request and wait for its transaction; starts and ends at a falling edge
  task automatic send_req(req_e req, logic [31:0] now_ms, logic [31:0] preset_ms);
    while (tx_idle_en && $urandom_range(99) < 31) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {preset_ms, now_ms};
    s_user  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    display_sb.note_request(req, now_ms, preset_ms);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every owed result, then let the pipeline settle
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (display_sb.expected_displays.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_frac(logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    display_sb.frac_shown = value;
  endtask

  // mostly a plausible request stream on an advancing tick, some noise
  task automatic send_random_item();
    int unsigned pick;
    logic [31:0] pre;
    pick = $urandom_range(99);
    pre  = $urandom;
    if (pick < 68) begin
      tick += ($urandom_range(9) == 0) ? $urandom_range(200000) : $urandom_range(40);
      send_req(REQ_UPDATE, tick, pre);
    end else if (pick < 78) begin
      send_req(REQ_START, tick, pre);
    end else if (pick < 86) begin
      send_req(REQ_STOP, tick, pre);
    end else if (pick < 93) begin
      if ($urandom_range(1) == 1) pre = $urandom_range(7_200_000);
      send_req(REQ_PRESET, tick, pre);
    end else begin
      send_req(req_e'($urandom_range(3)), $urandom, pre);
    end
  endtask

  initial begin
    logic [31:0] t0;
    logic [1:0]  frac_plan[6];
    display_sb = new();
    frac_plan  = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0};
    t0         = 32'hFFFF_FF00;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle requests at reset, wrap of the tick, layout extremes
    send_req(REQ_UPDATE, 32'h0, 32'h0);
    send_req(REQ_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_START, t0, 32'h0);
    send_req(REQ_START, 32'd5, 32'h0);
    send_req(REQ_UPDATE, t0 + 32'd1234, 32'h0);
    send_req(REQ_UPDATE, t0 + 32'd1234, 32'h0);
    send_req(REQ_UPDATE, t0 + 32'd3_599_999, 32'h0);
    send_req(REQ_UPDATE, t0 + 32'd3_600_000, 32'h0);
    send_req(REQ_STOP, 32'h0, 32'h0);
    send_req(REQ_STOP, 32'h0, 32'h0);
    send_req(REQ_UPDATE, 32'h1234_5678, 32'h0);
    send_req(REQ_PRESET, 32'h0, 32'hFFFF_FFFF);
    send_req(REQ_UPDATE, 32'h0, 32'h0);
    send_req(REQ_PRESET, 32'hAAAA_AAAA, 32'h0);
    send_req(REQ_UPDATE, 32'h5555_5555, 32'h0);
    send_req(REQ_PRESET, 32'h0, 32'd36_000_000);
    send_req(REQ_UPDATE, 32'h0, 32'h0);
    send_req(REQ_PRESET, 32'h0, 32'd360_000_000);
    send_req(REQ_UPDATE, 32'h0, 32'h0);
    send_req(REQ_PRESET, 32'h0, 32'd9_990);
    send_req(REQ_UPDATE, 32'h0, 32'h0);
    send_req(REQ_START, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(REQ_UPDATE, 32'h5555_5555 + 32'd123_456_789, 32'h0);
    send_req(REQ_PRESET, 32'h0F0F_0F0F, 32'd42_000);
    send_req(REQ_UPDATE, 32'h0F0F_0F0F + 32'd55, 32'h0);
    send_req(REQ_STOP, 32'h0, 32'h0);
    wait_idle();

    // random phases, one blanking setting each
    foreach (frac_plan[p]) begin
      write_frac(frac_plan[p]);
      tx_idle_en = (p != 1 && p != 2);
      rx_idle_en = (p != 1);
      if (p == 2) rx_hold_pending = 1'b1;
      tick = $urandom;
      repeat (315) send_random_item();
      wait_idle();
    end

    if (display_sb.errors == 0 && display_sb.expected_displays.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[stopwatch_time_display.f]
src/swtd_pkg.sv
src/swtd_front.sv
src/swtd_queue.sv
src/swtd_back.sv
src/stopwatch_time_display.sv
verif/tb_stopwatch_time_display.sv
